// File: rtl/core/lcdns_pkg.sv
// ----------------------------------------------------------------------------
// lcdns_pkg - shared types and constants of the character LCD nibble sequencer
// Request codes, command bytes, widths and the display address rule.
// ----------------------------------------------------------------------------
package lcdns_pkg;

  // Field widths
  localparam int unsigned ReqTypeW   = 4;
  localparam int unsigned CharW      = 8;
  localparam int unsigned ColumnW    = 6;
  localparam int unsigned RowW       = 2;
  localparam int unsigned NibbleW    = 4;
  localparam int unsigned LineCountW = 3;
  localparam int unsigned CplW       = 6;
  localparam int unsigned CountW     = 8;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 8;

  // Request codes
  typedef enum logic [ReqTypeW-1:0] {
    ReqInit       = 4'd0,
    ReqClear      = 4'd1,
    ReqCursorOn   = 4'd2,
    ReqCursorOff  = 4'd3,
    ReqDisplayOn  = 4'd4,
    ReqDisplayOff = 4'd5,
    ReqGoto       = 4'd6,
    ReqWrite      = 4'd7,
    ReqWrapWrite  = 4'd8
  } req_e;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgLineCount    = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgCharsPerLine = 2'd1;

  localparam logic [LineCountW-1:0] LineCountReset    = 3'd2;
  localparam logic [CplW-1:0]       CharsPerLineReset = 6'd16;
  localparam logic [LineCountW-1:0] LineCountTwo      = 3'd2;
  localparam logic [LineCountW-1:0] LineCountFour     = 3'd4;

  // Command bytes and init nibbles
  localparam logic [7:0] CmdClear       = 8'h01;
  localparam logic [7:0] CmdEntryMode   = 8'h06;
  localparam logic [7:0] CmdDisplayOn   = 8'h0C;
  localparam logic [7:0] CmdDisplayOff  = 8'h08;
  localparam logic [7:0] CmdCursorBits  = 8'h03;
  localparam logic [7:0] CmdCursorOn    = 8'h0F;
  localparam logic [7:0] CmdFuncSet     = 8'h20;
  localparam logic [7:0] CmdFuncSetTwo  = 8'h28;
  localparam logic [7:0] SetDdram       = 8'h80;
  localparam logic [7:0] OddLineOffset  = 8'd20;
  localparam logic [NibbleW-1:0] InitNibble     = 4'h3;
  localparam logic [NibbleW-1:0] InitNibbleLast = 4'h2;

  // One queued byte of a run
  typedef struct packed {
    logic [7:0] data;
    logic       rs;
    logic       lw;
  } slot_t;

  // Divider request and response
  typedef struct packed {
    logic              start;
    logic [CountW-1:0] dividend;
    logic [CplW-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [CountW-1:0] quotient;
    logic [CplW-1:0]   remainder;
  } div_rsp_t;

  // DDRAM address command for a column and line, modulo 256
  function automatic logic [7:0] lcdns_addr(input logic [ColumnW-1:0]    col,
                                            input logic [CountW-1:0]     line,
                                            input logic [LineCountW-1:0] lc);
    logic [7:0] base;
    logic [7:0] lm1;
    base = 8'd0;
    lm1  = line - 8'd1;
    if (lc == LineCountTwo) begin
      base = {line[1:0], 6'd0};
    end else if (lc == LineCountFour) begin
      if (line == 8'd0 || line == 8'd2) begin
        base = {line[2:1], 6'd0};
      end else begin
        base = {lm1[2:1], 6'd0} + OddLineOffset;
      end
    end
    return base + {2'd0, col} + SetDdram;
  endfunction

endpackage

// File: rtl/core/lcdns_if.sv
// ----------------------------------------------------------------------------
// lcdns_if - valid/ready channels of the character LCD nibble sequencer
// Request, configuration write and nibble output channels.
// ----------------------------------------------------------------------------
interface lcdns_req_if;
  logic                              valid;
  logic                              ready;
  logic [lcdns_pkg::ReqTypeW-1:0]    req_type;
  logic [lcdns_pkg::CharW-1:0]       char_code;
  logic [lcdns_pkg::ColumnW-1:0]     column;
  logic [lcdns_pkg::RowW-1:0]        row;
  logic                              string_start;

  modport source (output valid, req_type, char_code, column, row, string_start,
                  input ready);
  modport sink   (input valid, req_type, char_code, column, row, string_start,
                  output ready);
endinterface

interface lcdns_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [lcdns_pkg::CfgIdxW-1:0]     index;
  logic [lcdns_pkg::CfgDataW-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

interface lcdns_out_if;
  logic                              valid;
  logic                              ready;
  logic [lcdns_pkg::NibbleW-1:0]     nibble;
  logic                              reg_select;
  logic                              long_wait;
  logic                              last;

  modport source (output valid, nibble, reg_select, long_wait, last, input ready);
  modport sink   (input valid, nibble, reg_select, long_wait, last, output ready);
endinterface

// File: rtl/core/lcdns_divider.sv
// ----------------------------------------------------------------------------
// lcdns_divider - iterative restoring divider
// Divides the wrap count by characters per line, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module lcdns_divider (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lcdns_pkg::div_req_t req_i,
  output lcdns_pkg::div_rsp_t rsp_o
);
  import lcdns_pkg::*;

  localparam int unsigned StepW = $clog2(CountW);

  logic                busy_q;
  logic                done_q;
  logic [StepW-1:0]    step_q;
  logic [CountW-1:0]   dvd_q;
  logic [CplW-1:0]     rem_q;
  logic [CplW:0]       trial;
  logic                fits;
  logic [CplW:0]       diff;

  // Shift in the next dividend bit and try the subtraction
  assign trial = {rem_q, dvd_q[CountW-1]};
  assign fits  = trial >= {1'b0, req_i.divisor};
  assign diff  = trial - {1'b0, req_i.divisor};

  // Control: run one step per cycle, flag completion for a cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + StepW'(1);
        if (step_q == StepW'(CountW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: quotient bits replace dividend bits from the bottom
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.dividend;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[CountW-2:0], fits};
      rem_q <= fits ? diff[CplW-1:0] : trial[CplW-1:0];
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = dvd_q;
  assign rsp_o.remainder = rem_q;

endmodule

// File: rtl/core/char_lcd_nibble_sequencer.sv
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer - HD44780-style 4-bit LCD nibble sequencer
// Turns each request into a run of nibble beats, high nibble first.
// ----------------------------------------------------------------------------
// Sequence: an accepted request moves to the emit state, or first to the divider
//   wait state for a wrapped write with a nonzero line width; beats are registered.
// Requests: a new request is taken only once the last run is through (idle),
//   twelve nibbles per run at most.
// Reset: cursor flag and wrap count clear; line count 2, chars per line 16.
module char_lcd_nibble_sequencer (
  input  logic             clk_i,
  input  logic             rst_ni,
  lcdns_req_if.sink        req_i,
  lcdns_cfg_if.sink        cfg_i,
  lcdns_out_if.source      out_o
);
  import lcdns_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_EMIT = 3'b100
  } state_e;

  state_e                 state_q, state_d;
  logic [LineCountW-1:0]  lc_q;
  logic [CplW-1:0]        cpl_q;
  logic                   cursor_q, cursor_d;
  logic [CountW-1:0]      wrap_q, wrap_d;
  slot_t                  slot_q [4];
  slot_t                  slot_d [4];
  logic [1:0]             last_idx_q, last_idx_d;
  logic [1:0]             idx_q, idx_d;
  logic                   half_q, half_d;
  logic                   pre_act_q, pre_act_d;
  logic [1:0]             pre_cnt_q, pre_cnt_d;

  logic                   out_valid_q;
  logic [NibbleW-1:0]     out_nib_q;
  logic                   out_rs_q, out_lw_q, out_last_q;

  logic                   req_acc;
  logic                   load;
  logic [CountW-1:0]      count_new;
  slot_t                  cur_slot;
  logic [NibbleW-1:0]     nib_c;
  logic                   rs_c, lw_c, last_c;
  div_req_t               div_req;
  div_rsp_t               div_rsp;

  assign req_i.ready = (state_q == S_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;
  assign load        = (state_q == S_EMIT) && (!out_valid_q || out_o.ready);
  assign count_new   = (req_i.string_start ? CountW'(0) : wrap_q) + CountW'(1);

  // Divider for the line wrap
  lcdns_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Configuration writes; unknown indexes drop
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lc_q  <= LineCountReset;
      cpl_q <= CharsPerLineReset;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == CfgLineCount) begin
        lc_q <= cfg_i.data[LineCountW-1:0];
      end else if (cfg_i.index == CfgCharsPerLine) begin
        cpl_q <= cfg_i.data[CplW-1:0];
      end
    end
  end

  // Current nibble beat
  always_comb begin
    cur_slot = slot_q[idx_q];
    if (pre_act_q) begin
      nib_c  = (pre_cnt_q == 2'd3) ? InitNibbleLast : InitNibble;
      rs_c   = 1'b0;
      lw_c   = 1'b0;
      last_c = 1'b0;
    end else begin
      nib_c  = half_q ? cur_slot.data[3:0] : cur_slot.data[7:4];
      rs_c   = cur_slot.rs;
      lw_c   = half_q && cur_slot.lw;
      last_c = half_q && (idx_q == last_idx_q);
    end
  end

  // Sequencer: decode request, wait for divider, advance through the run
  always_comb begin
    state_d    = state_q;
    cursor_d   = cursor_q;
    wrap_d     = wrap_q;
    slot_d     = slot_q;
    last_idx_d = last_idx_q;
    idx_d      = idx_q;
    half_d     = half_q;
    pre_act_d  = pre_act_q;
    pre_cnt_d  = pre_cnt_q;
    div_req    = '0;
    unique case (state_q)
      S_IDLE: begin
        if (req_acc) begin
          idx_d      = 2'd0;
          half_d     = 1'b0;
          pre_act_d  = 1'b0;
          pre_cnt_d  = 2'd0;
          last_idx_d = 2'd0;
          state_d    = S_EMIT;
          unique case (req_e'(req_i.req_type))
            ReqInit: begin
              slot_d[0]  = '{(lc_q == LineCountTwo) ? CmdFuncSetTwo : CmdFuncSet,
                             1'b0, 1'b0};
              slot_d[1]  = '{CmdEntryMode, 1'b0, 1'b0};
              slot_d[2]  = '{CmdDisplayOn, 1'b0, 1'b0};
              slot_d[3]  = '{CmdClear, 1'b0, 1'b1};
              last_idx_d = 2'd3;
              pre_act_d  = 1'b1;
              cursor_d   = 1'b0;
            end
            ReqClear:      slot_d[0] = '{CmdClear, 1'b0, 1'b1};
            ReqCursorOn: begin
              slot_d[0] = '{CmdCursorOn, 1'b0, 1'b0};
              cursor_d  = 1'b1;
            end
            ReqCursorOff: begin
              slot_d[0] = '{CmdDisplayOn, 1'b0, 1'b0};
              cursor_d  = 1'b0;
            end
            ReqDisplayOn:
              slot_d[0] = '{CmdDisplayOn | (cursor_q ? CmdCursorBits : 8'd0), 1'b0, 1'b0};
            ReqDisplayOff:
              slot_d[0] = '{CmdDisplayOff | (cursor_q ? CmdCursorBits : 8'd0), 1'b0, 1'b0};
            ReqGoto:
              slot_d[0] = '{lcdns_addr(req_i.column, {6'd0, req_i.row}, lc_q),
                            1'b0, 1'b0};
            ReqWrite:      slot_d[0] = '{req_i.char_code, 1'b1, 1'b0};
            ReqWrapWrite: begin
              wrap_d = count_new;
              if (req_i.string_start) begin
                slot_d[0]  = '{lcdns_addr('0, '0, lc_q), 1'b0, 1'b0};
                slot_d[1]  = '{req_i.char_code, 1'b1, 1'b0};
                last_idx_d = 2'd1;
              end else begin
                slot_d[0]  = '{req_i.char_code, 1'b1, 1'b0};
              end
              if (cpl_q != '0) begin
                div_req = '{start: 1'b1, dividend: count_new, divisor: cpl_q};
                state_d = S_DIV;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_DIV: begin
        div_req.divisor = cpl_q;
        if (div_rsp.done) begin
          if (div_rsp.remainder == '0) begin
            slot_d[last_idx_q + 2'd1] = '{lcdns_addr('0, div_rsp.quotient, lc_q),
                                          1'b0, 1'b0};
            last_idx_d = last_idx_q + 2'd1;
          end
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (load) begin
          if (pre_act_q) begin
            pre_cnt_d = pre_cnt_q + 2'd1;
            if (pre_cnt_q == 2'd3) begin
              pre_act_d = 1'b0;
            end
          end else if (!half_q) begin
            half_d = 1'b1;
          end else begin
            half_d = 1'b0;
            idx_d  = idx_q + 2'd1;
            if (idx_q == last_idx_q) begin
              state_d = S_IDLE;
            end
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cursor_q   <= 1'b0;
      wrap_q     <= '0;
      last_idx_q <= 2'd0;
      idx_q      <= 2'd0;
      half_q     <= 1'b0;
      pre_act_q  <= 1'b0;
      pre_cnt_q  <= 2'd0;
    end else begin
      state_q    <= state_d;
      cursor_q   <= cursor_d;
      wrap_q     <= wrap_d;
      last_idx_q <= last_idx_d;
      idx_q      <= idx_d;
      half_q     <= half_d;
      pre_act_q  <= pre_act_d;
      pre_cnt_q  <= pre_cnt_d;
    end
  end

  // Byte queue
  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  // Output register: hold a beat until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_nib_q  <= nib_c;
      out_rs_q   <= rs_c;
      out_lw_q   <= lw_c;
      out_last_q <= last_c;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.nibble     = out_nib_q;
  assign out_o.reg_select = out_rs_q;
  assign out_o.long_wait  = out_lw_q;
  assign out_o.last       = out_last_q;

`ifndef SYNTHESIS
  // A waiting beat stays put until the sink takes it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |=>
      (out_o.valid && $stable(out_o.nibble) && $stable(out_o.reg_select) &&
       $stable(out_o.long_wait) && $stable(out_o.last)))
    else $error("waiting output beat changed before it was taken");

  // Divider completes only while the sequencer waits on it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_DIV))
    else $error("divider completion outside wait state");

  // Long wait only follows the clear command's low nibble
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.long_wait) |-> (out_o.nibble == CmdClear[3:0] && !out_o.reg_select))
    else $error("long wait on a beat other than clear low nibble");

  // A new run starts from the first byte, high nibble
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc |=> (idx_q == 2'd0 && !half_q))
    else $error("run did not restart at first nibble");
`endif

endmodule

// File: verif/char_lcd_nibble_sequencer_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer_test - self-checking bench of the nibble sequencer
// Drives LCD requests and register writes through valid/ready channels and
// predicts every nibble beat from its own copy of the cursor flag, the wrap
// count and the two registers. Directed tests cover each request, the address
// rules, line wrapping and count overflow; a long output hold-off and a random
// run with random idling on both sides follow.
// ----------------------------------------------------------------------------
module char_lcd_nibble_sequencer_test;
  import lcdns_pkg::*;

  localparam int unsigned LineStride   = 64;
  localparam int unsigned SettleCycles = 32;
  localparam int unsigned MaxIdle      = 16;
  localparam int unsigned HoldOffLen   = 400;
  localparam logic [CfgIdxW-1:0] CfgSpareLo = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpareHi = 2'd3;

  typedef struct packed {
    logic [NibbleW-1:0] nibble;
    logic               reg_select;
    logic               long_wait;
    logic               last;
  } nib_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  lcdns_req_if req_if ();
  lcdns_cfg_if cfg_if ();
  lcdns_out_if out_if ();

  char_lcd_nibble_sequencer i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .cfg_i  (cfg_if),
    .out_o  (out_if)
  );

  // Predicted beats, oldest first
  nib_beat_t nibble_q[$];
  int unsigned mismatch_count;

  // Predictor copy of the block state and registers
  logic [LineCountW-1:0] lines_cfg;
  logic [CplW-1:0]       cpl_cfg;
  logic                  cursor_set;
  logic [CountW-1:0]     wrap_cnt;

  // Idling controls
  logic        src_no_gaps;
  logic        snk_no_stalls;
  int unsigned stall_left;
  int unsigned hold_left;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // DDRAM address command for a column and line, modulo 256
  function automatic logic [7:0] lcd_addr(input logic [ColumnW-1:0] col,
                                          input int unsigned line);
    int unsigned a;
    if (lines_cfg == LineCountTwo) begin
      a = LineStride * line + col + SetDdram;
    end else if (lines_cfg == LineCountFour) begin
      if (line == 0 || line == 2) begin
        a = LineStride * (line / 2) + col + SetDdram;
      end else begin
        a = LineStride * ((line - 1) / 2) + OddLineOffset + col + SetDdram;
      end
    end else begin
      a = col + SetDdram;
    end
    return a[7:0];
  endfunction

  // Split a byte into two beats, high nibble first
  function automatic void add_byte(ref nib_beat_t run[$], input logic [7:0] b,
                                   input logic rs, input logic lw);
    run.push_back('{nibble: b[7:4], reg_select: rs, long_wait: 1'b0, last: 1'b0});
    run.push_back('{nibble: b[3:0], reg_select: rs, long_wait: lw, last: 1'b0});
  endfunction

  // Work out the beats of one accepted request and advance the state
  function automatic void predict_req(input logic [ReqTypeW-1:0] kind,
                                      input logic [CharW-1:0] ch,
                                      input logic [ColumnW-1:0] col,
                                      input logic [RowW-1:0] row,
                                      input logic start);
    nib_beat_t run[$];
    case (kind)
      ReqInit: begin
        run.push_back('{InitNibble, 1'b0, 1'b0, 1'b0});
        run.push_back('{InitNibble, 1'b0, 1'b0, 1'b0});
        run.push_back('{InitNibble, 1'b0, 1'b0, 1'b0});
        run.push_back('{InitNibbleLast, 1'b0, 1'b0, 1'b0});
        add_byte(run, (lines_cfg == LineCountTwo) ? CmdFuncSetTwo : CmdFuncSet, 1'b0, 1'b0);
        add_byte(run, CmdEntryMode, 1'b0, 1'b0);
        add_byte(run, CmdDisplayOn, 1'b0, 1'b0);
        add_byte(run, CmdClear, 1'b0, 1'b1);
        cursor_set = 1'b0;
      end
      ReqClear: add_byte(run, CmdClear, 1'b0, 1'b1);
      ReqCursorOn: begin
        add_byte(run, CmdCursorOn, 1'b0, 1'b0);
        cursor_set = 1'b1;
      end
      ReqCursorOff: begin
        add_byte(run, CmdDisplayOn, 1'b0, 1'b0);
        cursor_set = 1'b0;
      end
      ReqDisplayOn:
        add_byte(run, CmdDisplayOn | (cursor_set ? CmdCursorBits : 8'h00), 1'b0, 1'b0);
      ReqDisplayOff:
        add_byte(run, CmdDisplayOff | (cursor_set ? CmdCursorBits : 8'h00), 1'b0, 1'b0);
      ReqGoto: add_byte(run, lcd_addr(col, 32'(row)), 1'b0, 1'b0);
      ReqWrite: add_byte(run, ch, 1'b1, 1'b0);
      ReqWrapWrite: begin
        // home and restart the count on a new string
        if (start) begin
          add_byte(run, lcd_addr('0, 0), 1'b0, 1'b0);
          wrap_cnt = '0;
        end
        add_byte(run, ch, 1'b1, 1'b0);
        wrap_cnt = wrap_cnt + 8'd1;
        if (cpl_cfg != '0 && (wrap_cnt % cpl_cfg) == '0) begin
          add_byte(run, lcd_addr('0, 32'(wrap_cnt / cpl_cfg)), 1'b0, 1'b0);
        end
      end
      default: ;
    endcase
    if (run.size() != 0) begin
      run[run.size()-1].last = 1'b1;
    end
    foreach (run[k]) begin
      nibble_q.push_back(run[k]);
    end
  endfunction

  // Offer one request beat; valid stays up for a back-to-back successor
  task automatic send_req(input logic [ReqTypeW-1:0] kind, input logic [CharW-1:0] ch,
                          input logic [ColumnW-1:0] col, input logic [RowW-1:0] row,
                          input logic start);
    int unsigned gap;
    req_if.valid        = 1'b1;
    req_if.req_type     = kind;
    req_if.char_code    = ch;
    req_if.column       = col;
    req_if.row          = row;
    req_if.string_start = start;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    predict_req(kind, ch, col, row, start);
    @(negedge clk_i);
    gap = src_no_gaps ? 0 : $urandom_range(0, MaxIdle);
    if (gap != 0) begin
      req_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // Request with random payload fields
  task automatic send_rand(input logic [ReqTypeW-1:0] kind, input logic start);
    logic [31:0] r;
    r = $urandom();
    send_req(kind, r[7:0], r[13:8], r[15:14], start);
  endtask

  // Drop valid, wait for every predicted beat, then let the block go quiet
  task automatic settle();
    req_if.valid = 1'b0;
    while (nibble_q.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = val;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    if (idx == CfgLineCount) begin
      lines_cfg = val[LineCountW-1:0];
    end else if (idx == CfgCharsPerLine) begin
      cpl_cfg = val[CplW-1:0];
    end
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
    @(negedge clk_i);
  endtask

  // Set both registers on an idle block; spare data bits are random
  task automatic configure(input logic [LineCountW-1:0] lc, input logic [CplW-1:0] cpl);
    logic [31:0] pad;
    pad = $urandom();
    settle();
    write_reg(CfgLineCount, {pad[4:0], lc});
    write_reg(CfgCharsPerLine, {pad[9:8], cpl});
  endtask

  // Check each output beat against the oldest prediction
  always @(posedge clk_i) begin : check_beats
    nib_beat_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (nibble_q.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual nibble %h rs %b lw %b last %b",
                 $time, out_if.nibble, out_if.reg_select, out_if.long_wait, out_if.last);
        mismatch_count++;
      end else begin
        want = nibble_q.pop_front();
        if (out_if.nibble !== want.nibble) begin
          $display("%0t: nibble, expected %h, actual %h", $time, want.nibble, out_if.nibble);
          mismatch_count++;
        end
        if (out_if.reg_select !== want.reg_select) begin
          $display("%0t: reg_select, expected %b, actual %b",
                   $time, want.reg_select, out_if.reg_select);
          mismatch_count++;
        end
        if (out_if.long_wait !== want.long_wait) begin
          $display("%0t: long_wait, expected %b, actual %b",
                   $time, want.long_wait, out_if.long_wait);
          mismatch_count++;
        end
        if (out_if.last !== want.last) begin
          $display("%0t: last, expected %b, actual %b", $time, want.last, out_if.last);
          mismatch_count++;
        end
      end
      stall_left = snk_no_stalls ? 0 : $urandom_range(0, MaxIdle);
    end
  end

  // Drive ready: long hold-off first, then the per-beat stall
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left != 0) begin
        out_if.ready = 1'b0;
        hold_left--;
      end else if (stall_left != 0) begin
        out_if.ready = 1'b0;
        stall_left--;
      end else begin
        out_if.ready = 1'b1;
      end
    end
  end

  // Requests under the reset settings: two lines, sixteen characters
  task automatic test_reset_defaults();
    send_req(ReqInit, 8'h00, 6'd0, 2'd0, 1'b0);
    send_req(ReqGoto, 8'hFF, 6'd63, 2'd3, 1'b1);
    send_req(ReqWrapWrite, 8'h41, 6'd0, 2'd0, 1'b1);
    send_req(ReqWrapWrite, 8'h42, 6'd63, 2'd3, 1'b0);
  endtask

  // Every command, cursor flag tracking and unknown requests
  task automatic test_commands();
    send_rand(ReqCursorOn, 1'b0);
    send_rand(ReqDisplayOn, 1'b1);
    send_rand(ReqDisplayOff, 1'b0);
    send_rand(ReqInit, 1'b1);
    send_rand(ReqDisplayOn, 1'b0);
    send_rand(ReqCursorOn, 1'b0);
    send_rand(ReqCursorOff, 1'b1);
    send_rand(ReqDisplayOff, 1'b0);
    send_rand(ReqClear, 1'b0);
    send_req(ReqWrite, 8'h00, 6'd63, 2'd3, 1'b1);
    send_req(ReqWrite, 8'hFF, 6'd0, 2'd0, 1'b0);
    send_rand(4'd9, 1'b1);
    send_rand(4'd15, 1'b0);
    settle();
  endtask

  // Four-line rules, then one-line rule for line counts zero and seven
  task automatic test_address_rules();
    configure(LineCountFour, 6'd16);
    send_rand(ReqInit, 1'b0);
    send_req(ReqGoto, 8'h00, 6'd0, 2'd0, 1'b0);
    send_req(ReqGoto, 8'h00, 6'd63, 2'd1, 1'b0);
    send_req(ReqGoto, 8'h00, 6'd5, 2'd2, 1'b0);
    send_req(ReqGoto, 8'h00, 6'd0, 2'd3, 1'b0);
    configure(3'd0, 6'd16);
    send_req(ReqGoto, 8'h00, 6'd63, 2'd3, 1'b0);
    configure(3'd7, 6'd16);
    send_req(ReqGoto, 8'h00, 6'd10, 2'd2, 1'b0);
  endtask

  // One character per line, no wrapping at zero width, widest line
  task automatic test_wrapping();
    configure(LineCountFour, 6'd1);
    send_rand(ReqWrapWrite, 1'b1);
    send_rand(ReqWrapWrite, 1'b0);
    send_rand(ReqWrapWrite, 1'b0);
    configure(LineCountTwo, 6'd0);
    send_rand(ReqWrapWrite, 1'b1);
    send_rand(ReqWrapWrite, 1'b0);
    configure(LineCountTwo, 6'd63);
    send_rand(ReqWrapWrite, 1'b1);
  endtask

  // Run the wrap count round to zero, which counts as a line boundary
  task automatic test_count_overflow();
    src_no_gaps   = 1'b1;
    snk_no_stalls = 1'b1;
    configure(LineCountTwo, 6'd0);
    send_rand(ReqWrapWrite, 1'b1);
    repeat (254) send_rand(ReqWrapWrite, 1'b0);
    configure(LineCountTwo, 6'd3);
    send_rand(ReqWrapWrite, 1'b0);
    send_rand(ReqWrapWrite, 1'b0);
    src_no_gaps   = 1'b0;
    snk_no_stalls = 1'b0;
  endtask

  // Hold the output off while requests keep coming, so the input stalls
  task automatic test_output_hold_off();
    settle();
    @(posedge clk_i);
    hold_left = HoldOffLen;
    @(negedge clk_i);
    src_no_gaps = 1'b1;
    repeat (6) send_rand(ReqInit, 1'b0);
    send_rand(ReqWrapWrite, 1'b1);
    repeat (4) send_rand(ReqWrapWrite, 1'b0);
    src_no_gaps = 1'b0;
    settle();
  endtask

  // Random phases: mostly wrapped strings, some commands and noise
  task automatic test_random(input int unsigned goal);
    int unsigned sent;
    int unsigned phase_left;
    int unsigned pick;
    int unsigned len;
    logic [LineCountW-1:0] lc;
    logic [CplW-1:0] cpl;
    logic [31:0] r;
    sent       = 0;
    phase_left = 0;
    while (sent < goal) begin
      // new settings and idling style for each phase
      if (phase_left == 0) begin
        r = $urandom();
        case (r[1:0])
          2'd0:    lc = LineCountTwo;
          2'd1:    lc = LineCountFour;
          default: lc = r[4:2];
        endcase
        case ($urandom_range(0, 4))
          0:       cpl = 6'd0;
          1:       cpl = 6'd1;
          2:       cpl = 6'd40;
          3:       cpl = 6'd63;
          default: cpl = r[13:8];
        endcase
        configure(lc, cpl);
        if (r[16]) begin
          write_reg(r[17] ? CfgSpareHi : CfgSpareLo, r[31:24]);
        end
        src_no_gaps   = ($urandom_range(0, 3) == 0);
        snk_no_stalls = ($urandom_range(0, 3) == 0);
        phase_left    = $urandom_range(15, 40);
      end
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        // a string, now and then without its start marker
        len = $urandom_range(1, 45);
        send_rand(ReqWrapWrite, pick >= 5);
        repeat (len - 1) send_rand(ReqWrapWrite, 1'b0);
        sent += len;
      end else if (pick < 60) begin
        send_rand(ReqGoto, 1'($urandom_range(0, 1)));
        sent++;
      end else if (pick < 70) begin
        send_rand(ReqWrite, 1'($urandom_range(0, 1)));
        sent++;
      end else if (pick < 74) begin
        send_rand(ReqInit, 1'($urandom_range(0, 1)));
        sent++;
      end else if (pick < 95) begin
        send_rand(ReqTypeW'($urandom_range(1, 5)), 1'($urandom_range(0, 1)));
        sent++;
      end else begin
        send_rand(ReqTypeW'($urandom_range(9, 15)), 1'($urandom_range(0, 1)));
      end
      if (phase_left != 0) begin
        phase_left--;
      end
    end
  endtask

  initial begin
    rst_ni              = 1'b0;
    req_if.valid        = 1'b0;
    req_if.req_type     = '0;
    req_if.char_code    = '0;
    req_if.column       = '0;
    req_if.row          = '0;
    req_if.string_start = 1'b0;
    cfg_if.valid        = 1'b0;
    cfg_if.index        = '0;
    cfg_if.data         = '0;
    mismatch_count      = 0;
    lines_cfg           = LineCountReset;
    cpl_cfg             = CharsPerLineReset;
    cursor_set          = 1'b0;
    wrap_cnt            = '0;
    src_no_gaps         = 1'b0;
    snk_no_stalls       = 1'b0;
    stall_left          = 0;
    hold_left           = 0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    test_reset_defaults();
    test_commands();
    test_address_rules();
    test_wrapping();
    test_count_overflow();
    test_output_hold_off();
    test_random(40);
    settle();

    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run
  initial begin
    #4_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
